// ----- design/active_expired_priority_queue_top_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ACTIVE_EXPIRED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define ACTIVE_EXPIRED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AEPQ_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("AEPQ assertion failed");
`define AEPQ_ASSERT_RST(name, prop) \
    name: assert property (@(posedge i_clk) prop) \
        else $error("AEPQ reset assertion failed");
`else
`define AEPQ_ASSERT(name, prop)
`define AEPQ_ASSERT_RST(name, prop)
`endif

`endif

// ----- design/aepq_pkg.sv -----
package aepq_pkg;

    localparam int MAX_LEVELS = 16;
    localparam int MAX_TASKS  = 256;

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ID_W   = 8;
    localparam int CFG_W  = 5;
    localparam int PRIO_W = 5;
    localparam int OLVL_W = 4;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd4;

    localparam logic REG_LEVELS   = 1'b0;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_GET = 1'b1
    } t_op;

    typedef struct packed {
        logic             hit;
        logic             swap;
        logic [LVL_W-1:0] level;
    } t_scan;

endpackage

// ----- design/aepq_ram.sv -----
module aepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/aepq_scan.sv -----
module aepq_scan (
    input  logic [aepq_pkg::MAX_LEVELS-1:0] i_active_ne,
    input  logic [aepq_pkg::MAX_LEVELS-1:0] i_expired_ne,
    input  logic [aepq_pkg::CFG_W-1:0]      i_eff,
    output aepq_pkg::t_scan                 o_scan
);

    import aepq_pkg::*;

    logic [MAX_LEVELS-1:0] mask;
    logic [MAX_LEVELS-1:0] act_vec;
    logic [MAX_LEVELS-1:0] exp_vec;
    logic [LVL_W-1:0]      act_lvl;
    logic [LVL_W-1:0]      exp_lvl;

    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            mask[l] = (l < int'(i_eff));
        end
        act_vec = i_active_ne & mask;
        exp_vec = i_expired_ne & mask;
        act_lvl = '0;
        exp_lvl = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (act_vec[l]) begin
                act_lvl = LVL_W'(l);
            end
            if (exp_vec[l]) begin
                exp_lvl = LVL_W'(l);
            end
        end
        o_scan.swap  = ~|act_vec;
        o_scan.hit   = (|act_vec) | (|exp_vec);
        o_scan.level = (|act_vec) ? act_lvl : exp_lvl;
    end

endmodule

// ----- design/active_expired_priority_queue_top.sv -----
// A transaction accepted into stage A passes through stage B and the output register
// before its result shows. It moves into stage B only once stage B is empty, as a get
// needs the next-link memory read there before the list head can be rewritten.
// Reset is synchronous and active low; control state and list occupancy clear, the
// level count returns to four, and no memory clearing pass is needed.
`include "active_expired_priority_queue_top_macros.svh"

module active_expired_priority_queue_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [aepq_pkg::ID_W-1:0]    i_task_id,
    input  logic signed [aepq_pkg::PRIO_W-1:0] i_dyn_prio,
    input  logic [aepq_pkg::PRIO_W-1:0]  i_static_prio,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_task_valid,
    output logic [aepq_pkg::ID_W-1:0]    o_out_task,
    output logic [aepq_pkg::OLVL_W-1:0]  o_out_level,
    output logic                         o_to_expired,
    output logic                         o_banks_swapped,
    output logic                         o_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aepq_pkg::APB_AW-1:0]  paddr,
    input  logic [aepq_pkg::APB_DW-1:0]  pwdata,
    output logic [aepq_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    import aepq_pkg::*;

    logic [CFG_W-1:0]      r_levels;
    logic [CFG_W-1:0]      eff;

    logic                  r_a_valid;
    t_op                   r_a_op;
    logic [ID_W-1:0]       r_a_id;
    logic [PRIO_W-1:0]     r_a_dyn;
    logic [PRIO_W-1:0]     r_a_sp;

    logic                  r_b_valid;
    logic                  r_b_upd;
    logic                  r_b_bank;
    logic [LVL_W-1:0]      r_b_lvl;
    logic                  r_b_task_valid;
    logic [ID_W-1:0]       r_b_task;
    logic [OLVL_W-1:0]     r_b_level;
    logic                  r_b_to_exp;
    logic                  r_b_swapped;
    logic                  r_b_status;

    logic                  r_out_valid;
    logic                  r_out_task_valid;
    logic [ID_W-1:0]       r_out_task;
    logic [OLVL_W-1:0]     r_out_level;
    logic                  r_out_to_exp;
    logic                  r_out_swapped;
    logic                  r_out_status;

    logic                  r_bank;
    logic [MAX_LEVELS-1:0] r_ne [2];
    logic [ID_W-1:0]       r_head [2][MAX_LEVELS];
    logic [ID_W-1:0]       r_tail [2][MAX_LEVELS];

    logic                  cfg_wr;
    logic                  in_acc;
    logic                  a_adv;
    logic                  out_free;
    logic                  b_done;

    logic                  is_add;
    logic                  to_exp;
    logic signed [PRIO_W:0] add_lvl_s;
    logic                  add_ok;
    logic                  add_bank;
    logic [LVL_W-1:0]      add_lvl;
    t_scan                 scan;
    logic                  get_bank;
    logic                  sel_bank;
    logic [LVL_W-1:0]      sel_lvl;
    logic [ID_W-1:0]       sel_head;
    logic [ID_W-1:0]       sel_tail;
    logic                  sel_ne;
    logic                  get_last;

    logic                  ram_we;
    logic                  ram_re;
    logic [ID_W-1:0]       ram_rdata;

    logic                  n_b_task_valid;
    logic [ID_W-1:0]       n_b_task;
    logic [OLVL_W-1:0]     n_b_level;
    logic                  n_b_to_exp;
    logic                  n_b_swapped;
    logic                  n_b_status;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_LEVELS) ? APB_DW'(r_levels) : '0;

    assign eff      = (int'(r_levels) > MAX_LEVELS) ? CFG_W'(MAX_LEVELS) : r_levels;

    assign out_free = !r_out_valid || !i_stall;
    assign b_done   = r_b_valid && out_free;
    assign a_adv    = r_a_valid && !r_b_valid;
    assign o_stall  = r_a_valid && !a_adv;
    assign in_acc   = i_valid && !o_stall;

    assign is_add    = (r_a_op == OP_ADD);
    assign to_exp    = r_a_dyn[PRIO_W-1];
    assign add_lvl_s = to_exp ? ($signed({1'b0, r_a_sp}) - 6'sd1)
                              : $signed({r_a_dyn[PRIO_W-1], r_a_dyn});
    assign add_ok    = !add_lvl_s[PRIO_W] && (add_lvl_s[PRIO_W-1:0] < eff);
    assign add_bank  = to_exp ? ~r_bank : r_bank;
    assign add_lvl   = LVL_W'(add_lvl_s[PRIO_W-1:0]);

    aepq_scan u_scan (
        .i_active_ne  (r_ne[r_bank]),
        .i_expired_ne (r_ne[~r_bank]),
        .i_eff        (eff),
        .o_scan       (scan)
    );

    assign get_bank = scan.swap ? ~r_bank : r_bank;
    assign sel_bank = is_add ? add_bank : get_bank;
    assign sel_lvl  = is_add ? add_lvl : scan.level;
    assign sel_head = r_head[sel_bank][sel_lvl];
    assign sel_tail = r_tail[sel_bank][sel_lvl];
    assign sel_ne   = r_ne[sel_bank][sel_lvl];
    assign get_last = (sel_head == sel_tail);

    assign ram_we = a_adv && is_add && add_ok && sel_ne;
    assign ram_re = a_adv && !is_add && scan.hit && !get_last;

    aepq_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TASKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(sel_tail)),
        .i_wdata (r_a_id),
        .i_re    (ram_re),
        .i_raddr (ADDR_W'(sel_head)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_b_task_valid = 1'b0;
        n_b_task       = '0;
        n_b_level      = '0;
        n_b_to_exp     = 1'b0;
        n_b_swapped    = 1'b0;
        n_b_status     = STATUS_OK;
        if (is_add) begin
            if (add_ok) begin
                n_b_level  = OLVL_W'(add_lvl);
                n_b_to_exp = to_exp;
            end else begin
                n_b_status = STATUS_RANGE;
            end
        end else begin
            n_b_swapped = scan.swap;
            if (scan.hit) begin
                n_b_task_valid = 1'b1;
                n_b_task       = sel_head;
                n_b_level      = OLVL_W'(scan.level);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= LEVELS_RESET;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= 1'b0;
            r_ne[0]     <= '0;
            r_ne[1]     <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_LEVELS) begin
                r_levels <= pwdata[CFG_W-1:0];
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (b_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (a_adv) begin
                if (is_add) begin
                    if (add_ok) begin
                        r_ne[add_bank][add_lvl] <= 1'b1;
                    end
                end else begin
                    if (scan.swap) begin
                        r_bank <= ~r_bank;
                    end
                    if (scan.hit && get_last) begin
                        r_ne[get_bank][scan.level] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op  <= t_op'(i_op);
            r_a_id  <= i_task_id;
            r_a_dyn <= i_dyn_prio;
            r_a_sp  <= i_static_prio;
        end
        if (a_adv) begin
            r_b_upd        <= !is_add && scan.hit && !get_last;
            r_b_bank       <= sel_bank;
            r_b_lvl        <= sel_lvl;
            r_b_task_valid <= n_b_task_valid;
            r_b_task       <= n_b_task;
            r_b_level      <= n_b_level;
            r_b_to_exp     <= n_b_to_exp;
            r_b_swapped    <= n_b_swapped;
            r_b_status     <= n_b_status;
            if (is_add && add_ok) begin
                r_tail[add_bank][add_lvl] <= r_a_id;
                if (!sel_ne) begin
                    r_head[add_bank][add_lvl] <= r_a_id;
                end
            end
        end
        if (b_done) begin
            if (r_b_upd) begin
                r_head[r_b_bank][r_b_lvl] <= ram_rdata;
            end
            r_out_task_valid <= r_b_task_valid;
            r_out_task       <= r_b_task;
            r_out_level      <= r_b_level;
            r_out_to_exp     <= r_b_to_exp;
            r_out_swapped    <= r_b_swapped;
            r_out_status     <= r_b_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_task_valid    = r_out_task_valid;
    assign o_out_task      = r_out_task;
    assign o_out_level     = r_out_level;
    assign o_to_expired    = r_out_to_exp;
    assign o_banks_swapped = r_out_swapped;
    assign o_status        = r_out_status;

    `AEPQ_ASSERT(a_b_held, r_b_valid && !b_done |=> r_b_valid && $stable(r_b_lvl))
    `AEPQ_ASSERT(a_add_excl, r_out_valid && r_out_to_exp |-> !r_out_swapped && !r_out_task_valid)
    `AEPQ_ASSERT(a_link_read, ram_re |=> r_b_valid && r_b_upd && r_b_task_valid)
    `AEPQ_ASSERT_RST(a_reset_clear, !i_rst_n |=> !r_a_valid && !r_b_valid && !r_out_valid)

endmodule
